FILE: hdl/vimm_pkg.sv
// Shared types, constants and helpers for the vehicle immobilizer alarm controller.
`default_nettype none
package vimm_pkg;

  // Fixed field widths
  localparam int unsigned TIME_IN_WIDTH   = 32;
  localparam int unsigned CODE_WIDTH      = 8;
  localparam int unsigned ATTEMPT_WIDTH   = 4;
  localparam int unsigned CFG_DATA_WIDTH  = 32;
  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam int unsigned TIME_WIDTH_DEF  = 32;

  // Item kinds
  typedef enum logic [1:0] {
    OP_POLL     = 2'd0,
    OP_IR_REQ   = 2'd1,
    OP_VERIFIED = 2'd2,
    OP_WRAP     = 2'd3
  } vimm_op_t;

  // Status SMS codes
  typedef enum logic [1:0] {
    STAT_NONE      = 2'd0,
    STAT_ALERT_OFF = 2'd1,
    STAT_ADV_LOCK  = 2'd2
  } vimm_status_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KEY_CODE         = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ATTEMPTS_RELOAD  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNLOCK_COOLDOWN  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LOCK_LED_TIME    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNLOCK_LED_TIME  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IGNITION_HOLDOFF = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LOCATION_PERIOD  = 3'd6;

  // Configuration reset values
  localparam logic [CODE_WIDTH-1:0]     KEY_CODE_RST         = 8'hA2;
  localparam logic [ATTEMPT_WIDTH-1:0]  ATTEMPTS_RELOAD_RST  = 4'd2;
  localparam logic [CFG_DATA_WIDTH-1:0] UNLOCK_COOLDOWN_RST  = 32'd750000;
  localparam logic [CFG_DATA_WIDTH-1:0] LOCK_LED_TIME_RST    = 32'd750000;
  localparam logic [CFG_DATA_WIDTH-1:0] UNLOCK_LED_TIME_RST  = 32'd300000;
  localparam logic [CFG_DATA_WIDTH-1:0] IGNITION_HOLDOFF_RST = 32'd500000;
  localparam logic [CFG_DATA_WIDTH-1:0] LOCATION_PERIOD_RST  = 32'd3000000;

  typedef struct packed {
    vimm_op_t                 op;
    logic [TIME_IN_WIDTH-1:0] time_now;
    logic [CODE_WIDTH-1:0]    ir_frame_code;
    logic                     button_released;
    logic                     reply_valid;
  } vimm_in_t;

  typedef struct packed {
    logic       alarm_lamp;
    logic       engine_enable;
    logic       engine_run;
    logic       unlock_led;
    logic       sms_rx_enabled;
    logic [1:0] status_message;
    logic       send_location;
    logic       call_owner;
    logic       alert_active;
  } vimm_out_t;

  typedef struct packed {
    logic [CODE_WIDTH-1:0]     key_code;
    logic [ATTEMPT_WIDTH-1:0]  attempts_reload;
    logic [CFG_DATA_WIDTH-1:0] unlock_cooldown;
    logic [CFG_DATA_WIDTH-1:0] lock_led_time;
    logic [CFG_DATA_WIDTH-1:0] unlock_led_time;
    logic [CFG_DATA_WIDTH-1:0] ignition_holdoff;
    logic [CFG_DATA_WIDTH-1:0] location_period;
  } vimm_cfg_t;

  // Controller flags and the attempt counter
  typedef struct packed {
    logic                     unlock_pending;
    logic                     is_unlocked;
    logic                     led_lit;
    logic                     alert_mode;
    logic                     alert_acknowledged;
    logic                     tracking;
    logic                     reply_pending;
    logic                     advanced_lock;
    logic                     button_held;
    logic                     engine_on;
    logic                     alarm_pin;
    logic                     engine_enable_pin;
    logic                     rx_enabled;
    logic [ATTEMPT_WIDTH-1:0] attempts_left;
  } vimm_flags_t;

  localparam vimm_flags_t FLAGS_RST = '{
    unlock_pending:     1'b0,
    is_unlocked:        1'b0,
    led_lit:            1'b0,
    alert_mode:         1'b0,
    alert_acknowledged: 1'b0,
    tracking:           1'b0,
    reply_pending:      1'b0,
    advanced_lock:      1'b0,
    button_held:        1'b0,
    engine_on:          1'b0,
    alarm_pin:          1'b0,
    engine_enable_pin:  1'b1,
    rx_enabled:         1'b0,
    attempts_left:      4'd2
  };

  // Count down a wrong attempt, or enter alert once none are left
  function automatic vimm_flags_t wrong_attempt(vimm_flags_t f);
    vimm_flags_t r;
    r = f;
    if (f.attempts_left != '0) begin
      r.attempts_left = f.attempts_left - 4'd1;
    end else begin
      r.alert_mode = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/vimm_cfg.sv
// Configuration register file of the immobilizer alarm controller.
`default_nettype none
module vimm_cfg (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    wr_en,
  input  wire logic [vimm_pkg::CFG_INDEX_WIDTH-1:0]    wr_index,
  input  wire logic [vimm_pkg::CFG_DATA_WIDTH-1:0]     wr_data,
  output vimm_pkg::vimm_cfg_t                          cfg
);

  vimm_pkg::vimm_cfg_t cfg_r;
  vimm_pkg::vimm_cfg_t cfg_nxt;

  // Decode the write index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        vimm_pkg::CFG_KEY_CODE:
          cfg_nxt.key_code = wr_data[vimm_pkg::CODE_WIDTH-1:0];
        vimm_pkg::CFG_ATTEMPTS_RELOAD:
          cfg_nxt.attempts_reload = wr_data[vimm_pkg::ATTEMPT_WIDTH-1:0];
        vimm_pkg::CFG_UNLOCK_COOLDOWN:  cfg_nxt.unlock_cooldown  = wr_data;
        vimm_pkg::CFG_LOCK_LED_TIME:    cfg_nxt.lock_led_time    = wr_data;
        vimm_pkg::CFG_UNLOCK_LED_TIME:  cfg_nxt.unlock_led_time  = wr_data;
        vimm_pkg::CFG_IGNITION_HOLDOFF: cfg_nxt.ignition_holdoff = wr_data;
        vimm_pkg::CFG_LOCATION_PERIOD:  cfg_nxt.location_period  = wr_data;
        default: ;
      endcase
    end
  end

  // Hold the registers, load reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_code         <= vimm_pkg::KEY_CODE_RST;
      cfg_r.attempts_reload  <= vimm_pkg::ATTEMPTS_RELOAD_RST;
      cfg_r.unlock_cooldown  <= vimm_pkg::UNLOCK_COOLDOWN_RST;
      cfg_r.lock_led_time    <= vimm_pkg::LOCK_LED_TIME_RST;
      cfg_r.unlock_led_time  <= vimm_pkg::UNLOCK_LED_TIME_RST;
      cfg_r.ignition_holdoff <= vimm_pkg::IGNITION_HOLDOFF_RST;
      cfg_r.location_period  <= vimm_pkg::LOCATION_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: hdl/vimm_step.sv
// Per-transaction next-state and result logic of the immobilizer alarm controller.
`default_nettype none
module vimm_step #(
  parameter int unsigned TIME_WIDTH = vimm_pkg::TIME_WIDTH_DEF
) (
  input  wire vimm_pkg::vimm_cfg_t     cfg,
  input  wire vimm_pkg::vimm_in_t      item,
  input  wire vimm_pkg::vimm_flags_t   flags_cur,
  input  wire logic [TIME_WIDTH-1:0]   unlock_dl_cur,
  input  wire logic [TIME_WIDTH-1:0]   ignition_dl_cur,
  input  wire logic [TIME_WIDTH-1:0]   led_dl_cur,
  input  wire logic [TIME_WIDTH-1:0]   location_dl_cur,
  output vimm_pkg::vimm_flags_t        flags_nxt,
  output logic [TIME_WIDTH-1:0]        unlock_dl_nxt,
  output logic [TIME_WIDTH-1:0]        ignition_dl_nxt,
  output logic [TIME_WIDTH-1:0]        led_dl_nxt,
  output logic [TIME_WIDTH-1:0]        location_dl_nxt,
  output vimm_pkg::vimm_out_t          result
);

  logic [TIME_WIDTH-1:0] t_now;
  logic [TIME_WIDTH-1:0] cool_t, lock_led_t, unlock_led_t, holdoff_t, loc_per_t;
  logic                  key_hit;
  vimm_pkg::vimm_flags_t f;
  vimm_pkg::vimm_status_t status;
  logic                  loc, call;

  // Bring time and intervals to the deadline width
  assign t_now        = TIME_WIDTH'(item.time_now);
  assign cool_t       = TIME_WIDTH'(cfg.unlock_cooldown);
  assign lock_led_t   = TIME_WIDTH'(cfg.lock_led_time);
  assign unlock_led_t = TIME_WIDTH'(cfg.unlock_led_time);
  assign holdoff_t    = TIME_WIDTH'(cfg.ignition_holdoff);
  assign loc_per_t    = TIME_WIDTH'(cfg.location_period);
  assign key_hit      = (item.ir_frame_code == cfg.key_code);

  // Apply one transaction in handling order
  always_comb begin
    f               = flags_cur;
    unlock_dl_nxt   = unlock_dl_cur;
    ignition_dl_nxt = ignition_dl_cur;
    led_dl_nxt      = led_dl_cur;
    location_dl_nxt = location_dl_cur;
    status          = vimm_pkg::STAT_NONE;
    loc             = 1'b0;
    call            = 1'b0;
    unique case (item.op)
      vimm_pkg::OP_IR_REQ: begin
        if (!f.alert_mode && !f.engine_on) f.unlock_pending = 1'b1;
      end
      vimm_pkg::OP_VERIFIED: begin
        if (f.alert_mode) f.reply_pending = 1'b1;
      end
      vimm_pkg::OP_WRAP: begin
        unlock_dl_nxt   = '0;
        ignition_dl_nxt = '0;
        led_dl_nxt      = '0;
        location_dl_nxt = '0;
      end
      vimm_pkg::OP_POLL: begin
        // Owner reply
        if (f.reply_pending) begin
          if (item.reply_valid) begin
            f.rx_enabled         = 1'b0;
            f.alert_acknowledged = 1'b0;
            f.alert_mode         = 1'b0;
            f.tracking           = 1'b0;
            f.advanced_lock      = 1'b0;
            f.alarm_pin          = 1'b0;
            f.engine_enable_pin  = 1'b1;
            f.attempts_left      = cfg.attempts_reload;
            status               = vimm_pkg::STAT_ALERT_OFF;
          end else if (!f.advanced_lock) begin
            f.engine_enable_pin = 1'b0;
            f.advanced_lock     = 1'b1;
            status              = vimm_pkg::STAT_ADV_LOCK;
          end
          f.reply_pending = 1'b0;
        end
        // LED timeout
        if (f.led_lit && t_now >= led_dl_nxt) begin
          f.led_lit  = 1'b0;
          led_dl_nxt = '0;
        end
        // IR lock or unlock
        if (f.unlock_pending && t_now >= unlock_dl_nxt) begin
          if (f.is_unlocked) begin
            if (key_hit) begin
              f.is_unlocked = 1'b0;
              led_dl_nxt    = t_now + lock_led_t;
              f.led_lit     = 1'b1;
            end
          end else if (key_hit) begin
            f.attempts_left = cfg.attempts_reload;
            f.is_unlocked   = 1'b1;
            led_dl_nxt      = t_now + unlock_led_t;
            f.led_lit       = 1'b1;
          end else begin
            f = vimm_pkg::wrong_attempt(f);
          end
          unlock_dl_nxt = t_now + cool_t;
        end
        f.unlock_pending = 1'b0;
        // Ignition button
        if (f.button_held && item.button_released) begin
          f.button_held   = 1'b0;
          ignition_dl_nxt = t_now + holdoff_t;
        end else if (!item.button_released && !f.alert_mode && !f.button_held &&
                     t_now >= ignition_dl_nxt) begin
          if (f.is_unlocked) begin
            f.engine_on = !f.engine_on;
          end else begin
            f = vimm_pkg::wrong_attempt(f);
          end
          f.button_held = 1'b1;
        end
        // Location report
        if (f.tracking && t_now >= location_dl_nxt) begin
          loc             = 1'b1;
          location_dl_nxt = t_now + loc_per_t;
        end
        // Alert entry
        if (f.alert_mode && !f.alert_acknowledged) begin
          f.alarm_pin          = 1'b1;
          f.rx_enabled         = 1'b1;
          call                 = 1'b1;
          f.alert_acknowledged = 1'b1;
          f.tracking           = 1'b1;
          location_dl_nxt      = t_now + loc_per_t;
        end
      end
      default: ;
    endcase
  end

  // Drive the result from the updated state
  assign flags_nxt              = f;
  assign result.alarm_lamp      = f.alarm_pin;
  assign result.engine_enable   = f.engine_enable_pin;
  assign result.engine_run      = f.engine_on;
  assign result.unlock_led      = f.led_lit;
  assign result.sms_rx_enabled  = f.rx_enabled;
  assign result.status_message  = status;
  assign result.send_location   = loc;
  assign result.call_owner      = call;
  assign result.alert_active    = f.alert_mode;

endmodule
`default_nettype wire

FILE: hdl/vehicle_immobilizer_alarm_fsm_top.sv
// Top level of the vehicle immobilizer and alarm controller.
//
// Input channel in_valid/in_ready/in_data carries one transaction per item:
// a poll, an IR unlock request, an owner-verified event or a timer wrap.
// Output channel out_valid/out_ready/out_data returns exactly one result per
// item, in order, with pin levels and the SMS/call commands it raised.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes one
// register per transaction; cfg_ready is always high. Write it only while
// no item is in flight.
// An accepted item waits in the input register, passes through the step
// logic and moves into the result register once that register is free.
// Throughput: one item per cycle unless the receiver stalls, set by the
// single step-logic pass between the input and result registers.
// Reset (rst_n low, synchronous): both stages empty, state flags cleared,
// engine enable high, attempt counter 2, deadlines 0, registers at defaults.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; in_ready drops only when both are full.
`default_nettype none
module vehicle_immobilizer_alarm_fsm_top #(
  parameter int unsigned TIME_WIDTH = vimm_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire vimm_pkg::vimm_in_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output vimm_pkg::vimm_out_t                       out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [vimm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [vimm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  vimm_pkg::vimm_cfg_t   cfg;
  vimm_pkg::vimm_in_t    in_data_r;
  logic                  in_valid_r, in_valid_nxt;
  vimm_pkg::vimm_out_t   out_data_r, result;
  logic                  out_valid_r, out_valid_nxt;
  vimm_pkg::vimm_flags_t flags_r, flags_nxt;
  logic [TIME_WIDTH-1:0] unlock_dl_r, unlock_dl_nxt;
  logic [TIME_WIDTH-1:0] ignition_dl_r, ignition_dl_nxt;
  logic [TIME_WIDTH-1:0] led_dl_r, led_dl_nxt;
  logic [TIME_WIDTH-1:0] location_dl_r, location_dl_nxt;
  logic                  in_fire, advance;

  assign cfg_ready = 1'b1;

  vimm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  vimm_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .cfg             (cfg),
    .item            (in_data_r),
    .flags_cur       (flags_r),
    .unlock_dl_cur   (unlock_dl_r),
    .ignition_dl_cur (ignition_dl_r),
    .led_dl_cur      (led_dl_r),
    .location_dl_cur (location_dl_r),
    .flags_nxt       (flags_nxt),
    .unlock_dl_nxt   (unlock_dl_nxt),
    .ignition_dl_nxt (ignition_dl_nxt),
    .led_dl_nxt      (led_dl_nxt),
    .location_dl_nxt (location_dl_nxt),
    .result          (result)
  );

  // Advance the held item into the result register when that is free
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      flags_r       <= vimm_pkg::FLAGS_RST;
      unlock_dl_r   <= '0;
      ignition_dl_r <= '0;
      led_dl_r      <= '0;
      location_dl_r <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        flags_r       <= flags_nxt;
        unlock_dl_r   <= unlock_dl_nxt;
        ignition_dl_r <= ignition_dl_nxt;
        led_dl_r      <= led_dl_nxt;
        location_dl_r <= location_dl_nxt;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Engine enable is low exactly while advanced lock holds
  a_adv_lock: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.engine_enable_pin == !flags_r.advanced_lock)
    else $error("engine enable out of step with advanced lock");

  // Alarm lamp and acknowledgment only within alert mode
  a_alarm_in_alert: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r.alarm_pin || flags_r.alert_acknowledged) |-> flags_r.alert_mode)
    else $error("alarm state outside alert mode");

  // A call to the owner is only placed when alert mode is reported
  a_call_alert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.call_owner) |-> out_data.alert_active)
    else $error("call raised without alert mode");

  // A stalled result with a held item blocks new input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted with both stages full");

endmodule
`default_nettype wire
